/* hdl/handheld_bus_decode_and_latches_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the handheld bus glue
// Same-cycle and next-cycle implication checks with a synchronous reset gate.
// ----------------------------------------------------------------------------
`ifndef HANDHELD_BUS_DECODE_AND_LATCHES_TOP_ASSERT_SVH
`define HANDHELD_BUS_DECODE_AND_LATCHES_TOP_ASSERT_SVH

// cons must hold in the same cycle as ante
`define HBDL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define HBDL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/hbdl_pkg.sv */
// ----------------------------------------------------------------------------
// hbdl_pkg
// Types and constants shared by the handheld bus glue.
// ----------------------------------------------------------------------------
package hbdl_pkg;

    typedef enum logic [1:0] {
        OP_BUS_READ  = 2'd0,
        OP_BUS_WRITE = 2'd1,
        OP_PORT_READ = 2'd2,
        OP_KEY_EVENT = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        TGT_NONE_ZERO = 3'd0,
        TGT_RAM       = 3'd1,
        TGT_ROM       = 3'd2,
        TGT_LCD       = 3'd3,
        TGT_NONE_FF   = 3'd4
    } t_target;

    // I/O window groups: (addr - 0x100) >> 6
    localparam logic [3:0] GRP_LCD      = 4'h2;
    localparam logic [3:0] GRP_STANDBY  = 4'h3;
    localparam logic [3:0] GRP_PULSE_ON = 4'h4;
    localparam logic [3:0] GRP_PULSE_OFF = 4'h5;
    localparam logic [3:0] GRP_BEEP_ON  = 4'h6;
    localparam logic [3:0] GRP_BEEP_OFF = 4'h7;
    localparam logic [3:0] GRP_SCAN_CLR = 4'h8;
    localparam logic [3:0] GRP_SCAN_INC = 4'h9;
    localparam logic [3:0] GRP_RAM_BANK = 4'hA;
    localparam logic [3:0] GRP_ROM_BANK = 4'hB;

    localparam logic [9:0]  IO_BASE_OFF      = 10'h100;
    localparam logic [9:0]  OFF_BANK_RESET   = 10'h260;
    localparam logic [9:0]  OFF_RAM_BANK_INC = 10'h2A0;
    localparam logic [9:0]  OFF_ROM_BANK_INC = 10'h2E0;
    localparam logic [16:0] BANK_WIN_BASE    = 17'h04000;

    localparam int          KEY_ROWS      = 7;
    localparam logic [2:0]  KEY_ROW_ON    = 3'd7;
    localparam logic [7:0]  KEY_COL_MASK  = 8'h7C;
    localparam logic [10:0] SCAN_ROW_BASE = 11'h07F;
    localparam logic [10:0] SCAN_ALL_ONES = 11'h7FF;

    typedef struct packed {
        t_op         op;
        logic [15:0] addr;
        logic [7:0]  write_byte;
        logic [2:0]  key_row;
        logic [7:0]  key_mask;
        logic        key_pressed;
    } t_in_item;

    typedef struct packed {
        t_target     target;
        logic [16:0] mem_offset;
        logic        is_write;
        logic [7:0]  write_data;
        logic        lcd_data_select;
        logic [7:0]  port_value;
        logic        beep;
        logic        nmi_enable;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  ram_bank;
        logic [1:0]  rom_bank;
        logic [10:0] scan_counter;
        logic        pulse_on;
        logic        beeper_on;
        logic        nmi_on;
        logic        on_key_down;
    } t_ctl_state;

    typedef struct packed {
        logic       en;
        logic [2:0] row;
        logic [7:0] mask;
        logic       pressed;
    } t_key_update;

endpackage

/* hdl/hbdl_if.sv */
// ----------------------------------------------------------------------------
// hbdl_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface hbdl_in_if;
    import hbdl_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface hbdl_out_if;
    import hbdl_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/hbdl_decode.sv */
// ----------------------------------------------------------------------------
// hbdl_decode
// Address decode, latch actions and key event handling for one beat.
// ----------------------------------------------------------------------------
module hbdl_decode #(
    parameter int RAM_BANK_PAGES = 4,
    parameter int ROM_BANK_PAGES = 3,
    parameter int RAM_BYTES      = 81920
) (
    input  hbdl_pkg::t_in_item    i_item,
    input  hbdl_pkg::t_ctl_state  i_state,
    input  logic [7:0]            i_port_value,
    output hbdl_pkg::t_out_item   o_result,
    output hbdl_pkg::t_ctl_state  o_next_state,
    output hbdl_pkg::t_key_update o_key_upd
);
    import hbdl_pkg::*;

    logic [9:0]  io_off;
    logic [3:0]  io_grp;
    logic [16:0] ram_off;
    logic [16:0] rom_off;
    logic        ram_fits;
    logic        wr_op;

    assign wr_op  = (i_item.op == OP_BUS_WRITE);
    assign io_off = i_item.addr[9:0] - IO_BASE_OFF;
    assign io_grp = io_off[9:6];

    // fixed RAM below 0x4000, banked window above
    assign ram_off = (!i_item.addr[14]) ? {1'b0, i_item.addr}
                   : {1'b0, i_state.ram_bank, 14'b0} + BANK_WIN_BASE
                     + {3'b0, i_item.addr[13:0]};
    assign ram_fits = ({1'b0, ram_off} < 18'(RAM_BYTES));

    // 0xC000 window is ROM page 1; banked window is page 0 or 2 + bank - 1
    assign rom_off = i_item.addr[14] ? BANK_WIN_BASE + {3'b0, i_item.addr[13:0]}
                   : (i_state.rom_bank == 2'd0) ? {3'b0, i_item.addr[13:0]}
                   : {1'b0, i_state.rom_bank, 14'b0} + BANK_WIN_BASE
                     + {3'b0, i_item.addr[13:0]};

    always_comb begin
        o_result     = '0;
        o_next_state = i_state;
        o_key_upd    = '0;
        case (i_item.op)
            OP_BUS_READ, OP_BUS_WRITE: begin
                if (i_item.addr[15:8] == 8'h00) begin
                    o_result.target = TGT_NONE_ZERO;
                end else if (i_item.addr[15:10] == 6'b0) begin
                    if (io_grp == GRP_LCD) begin
                        o_result.target          = TGT_LCD;
                        o_result.lcd_data_select = i_item.addr[0];
                        o_result.is_write        = wr_op;
                    end else begin
                        case (io_grp)
                            GRP_STANDBY:   o_next_state.nmi_on    = 1'b0;
                            GRP_PULSE_ON:  o_next_state.pulse_on  = 1'b1;
                            GRP_PULSE_OFF: o_next_state.pulse_on  = 1'b0;
                            GRP_BEEP_ON:   o_next_state.beeper_on = 1'b1;
                            GRP_BEEP_OFF:  o_next_state.beeper_on = 1'b0;
                            GRP_SCAN_CLR:  o_next_state.scan_counter = '0;
                            GRP_SCAN_INC: begin
                                if (io_off == OFF_BANK_RESET) begin
                                    o_next_state.ram_bank = '0;
                                    o_next_state.rom_bank = '0;
                                end else begin
                                    o_next_state.scan_counter = i_state.scan_counter + 11'd1;
                                end
                            end
                            GRP_RAM_BANK: begin
                                if (io_off == OFF_RAM_BANK_INC) begin
                                    if ({1'b0, i_state.ram_bank} + 3'd1 < 3'(RAM_BANK_PAGES))
                                        o_next_state.ram_bank = i_state.ram_bank + 2'd1;
                                end else begin
                                    o_next_state.nmi_on = 1'b1;
                                end
                            end
                            GRP_ROM_BANK: begin
                                if (io_off == OFF_ROM_BANK_INC) begin
                                    if ({1'b0, i_state.rom_bank} + 3'd1 < 3'(ROM_BANK_PAGES))
                                        o_next_state.rom_bank = i_state.rom_bank + 2'd1;
                                end else begin
                                    o_next_state.nmi_on = 1'b0;
                                end
                            end
                            default: o_next_state = i_state;
                        endcase
                    end
                end else if (!i_item.addr[15]) begin
                    if (ram_fits) begin
                        o_result.target     = TGT_RAM;
                        o_result.mem_offset = ram_off;
                        o_result.is_write   = wr_op;
                    end else begin
                        o_result.target = TGT_NONE_FF;
                    end
                end else begin
                    // ROM writes are dropped
                    o_result.target     = TGT_ROM;
                    o_result.mem_offset = rom_off;
                end
                o_result.write_data = o_result.is_write ? i_item.write_byte : 8'h00;
            end
            OP_PORT_READ: begin
                o_result.port_value = i_port_value;
            end
            OP_KEY_EVENT: begin
                if (i_item.key_row == KEY_ROW_ON) begin
                    o_next_state.on_key_down = i_item.key_pressed;
                end else begin
                    o_key_upd.en      = 1'b1;
                    o_key_upd.row     = i_item.key_row;
                    o_key_upd.mask    = i_item.key_mask;
                    o_key_upd.pressed = i_item.key_pressed;
                end
            end
            default: o_result = '0;
        endcase
        o_result.beep       = o_next_state.beeper_on;
        o_result.nmi_enable = o_next_state.nmi_on;
    end

endmodule

/* hdl/hbdl_latches.sv */
// ----------------------------------------------------------------------------
// hbdl_latches
// Control latches, key matrix rows and keyboard port byte.
// ----------------------------------------------------------------------------
module hbdl_latches (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  hbdl_pkg::t_ctl_state  i_next_state,
    input  hbdl_pkg::t_key_update i_key_upd,
    output hbdl_pkg::t_ctl_state  o_state,
    output logic [7:0]            o_port_value
);
    import hbdl_pkg::*;

    t_ctl_state r_state;
    logic [7:0] r_key_rows [KEY_ROWS];
    logic [7:0] n_key_rows [KEY_ROWS];

    // key rows are active low: press clears, release sets
    always_comb begin
        for (int r = 0; r < KEY_ROWS; r++) begin
            if (i_key_upd.en && i_key_upd.row == 3'(r)) begin
                n_key_rows[r] = i_key_upd.pressed ? (r_key_rows[r] & ~i_key_upd.mask)
                                                  : (r_key_rows[r] | i_key_upd.mask);
            end else begin
                n_key_rows[r] = r_key_rows[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            for (int r = 0; r < KEY_ROWS; r++) r_key_rows[r] <= 8'hFF;
        end else if (i_step) begin
            r_state <= i_next_state;
            for (int r = 0; r < KEY_ROWS; r++) r_key_rows[r] <= n_key_rows[r];
        end
    end

    // counter 0 scans all rows; 0x7F with one bit low selects that row
    always_comb begin
        logic [7:0] all_rows;
        logic [7:0] sel_row;
        logic       any_sel;
        logic [7:0] kb;
        all_rows = 8'hFF;
        sel_row  = 8'h00;
        any_sel  = 1'b0;
        for (int r = 0; r < KEY_ROWS; r++) begin
            all_rows = all_rows & r_key_rows[r];
            if (r_state.scan_counter == (SCAN_ROW_BASE & ~(11'd1 << r))) begin
                sel_row = sel_row | r_key_rows[r];
                any_sel = 1'b1;
            end
        end
        if (r_state.scan_counter == 11'd0)
            kb = all_rows & KEY_COL_MASK;
        else if (any_sel)
            kb = sel_row & KEY_COL_MASK;
        else
            kb = KEY_COL_MASK;
        kb[1] = r_state.pulse_on || (r_state.scan_counter == SCAN_ALL_ONES);
        kb[7] = r_state.on_key_down;
        o_port_value = kb;
    end

    assign o_state = r_state;

endmodule

/* hdl/handheld_bus_decode_and_latches_top.sv */
// ----------------------------------------------------------------------------
// handheld_bus_decode_and_latches_top
// Bus glue of a small handheld: address decode, I/O latches, keyboard port.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one beat per bus read, bus write, keyboard port read or key
//   event; o_out returns exactly one result beat per input beat, in order.
//   Both channels are valid/ready; a beat moves when both are high.
//   A beat taken on i_in is held in the input register, then moves into the
//   result register to be offered on o_out. Throughput: one beat per cycle,
//   unstalled, set by the single input register feeding one result register.
//   Latch, bank and key-row updates happen as a beat moves from the input
//   register into the result register, so each beat sees all earlier ones.
//   If the receiver stalls, the result register holds; one more beat waits
//   in the input register, then i_in.ready drops until o_out drains.
//   Reset (i_rst_n low, synchronous) empties both registers, clears banks,
//   counter and latches, and sets all key rows to released.
// ----------------------------------------------------------------------------
module handheld_bus_decode_and_latches_top #(
    parameter int RAM_BANK_PAGES = 4,
    parameter int ROM_BANK_PAGES = 3,
    parameter int RAM_BYTES      = 81920
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hbdl_in_if.sink           i_in,
    hbdl_out_if.source        o_out
);
    import hbdl_pkg::*;

    // input register
    logic       r_in_valid;
    logic       n_in_valid;
    t_in_item   r_in;

    // result register
    logic       r_out_valid;
    logic       n_out_valid;
    t_out_item  r_out;

    logic        in_take;
    logic        step;     // beat moves input reg -> result reg
    t_out_item   result;
    t_ctl_state  cur_state;
    t_ctl_state  next_state;
    t_key_update key_upd;
    logic [7:0]  port_value;

    assign step    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step;
    assign in_take = i_in.valid && i_in.ready;

    assign n_in_valid  = in_take || (r_in_valid && !step);
    assign n_out_valid = step || (r_out_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) r_in <= i_in.payload;
        if (step)    r_out <= result;
    end

    hbdl_decode #(
        .RAM_BANK_PAGES (RAM_BANK_PAGES),
        .ROM_BANK_PAGES (ROM_BANK_PAGES),
        .RAM_BYTES      (RAM_BYTES)
    ) u_decode (
        .i_item       (r_in),
        .i_state      (cur_state),
        .i_port_value (port_value),
        .o_result     (result),
        .o_next_state (next_state),
        .o_key_upd    (key_upd)
    );

    hbdl_latches u_latches (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_next_state (next_state),
        .i_key_upd    (key_upd),
        .o_state      (cur_state),
        .o_port_value (port_value)
    );

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

/* hdl/hbdl_checker.sv */
// ----------------------------------------------------------------------------
// hbdl_checker
// Port-level checks for the handheld bus glue, bound to the top level.
// ----------------------------------------------------------------------------
`include "handheld_bus_decode_and_latches_top_assert.svh"

module hbdl_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input hbdl_pkg::t_out_item i_out_payload
);
    import hbdl_pkg::*;

    // both stages empty right after reset
    `HBDL_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !i_out_valid && i_in_ready, "not empty after reset")

    // stalled result holds
    `HBDL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_payload), "stalled result changed")

    // input back-pressure only while the result side is stalled
    `HBDL_ASSERT_NOW(a_in_ready, i_clk, i_rst_n, !i_in_ready, i_out_valid && !i_out_ready, "input stalled without output stall")

    // writes go only to RAM or LCD
    `HBDL_ASSERT_NOW(a_write_tgt, i_clk, i_rst_n, i_out_valid && i_out_payload.is_write, i_out_payload.target == TGT_RAM || i_out_payload.target == TGT_LCD, "write to non-writable target")

endmodule

bind handheld_bus_decode_and_latches_top hbdl_checker u_hbdl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);
